// ----- design/c3as_pkg.sv -----
`default_nettype none
package c3as_pkg;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  out_pixel;
        logic [11:0] out_row;
        logic [9:0]  out_col;
    } out_beat_t;

    localparam int CfgW = 24;
    localparam logic [2:0] REG_COEF_TOP = 3'd0;
    localparam logic [2:0] REG_COEF_MID = 3'd1;
    localparam logic [2:0] REG_COEF_BOT = 3'd2;
    localparam logic [2:0] REG_DIVISOR  = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;

    // Sum of nine products: 20 bits signed is enough.
    localparam int SumW = 20;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take an accepted beat: read line stores
        logic shift;     // update the window and stores, latch the result flag
        logic start_mac; // clear the accumulator
        logic mac;       // add one product
        logic [3:0] tap; // window tap for the product
        logic start_div; // load the divider
        logic div_step;  // one quotient bit
        logic finish;    // register the clamped result
    } c3as_cmd_t;

    typedef struct packed {
        logic emit; // the current pixel produces a result
    } c3as_sts_t;

endpackage
`default_nettype wire

// ----- design/conv3x3_abs_saturate.sv -----
`default_nettype none
// 3x3 convolution over a raster stream of 8-bit grey pixels. Two line stores
// and a 3x3 window feed a single multiplier that forms the nine products one
// per cycle; the sum plus half the divisor is divided by a bit-serial divider
// (truncating toward zero), then its magnitude is clamped to 255. Border pixels
// give no result. A pixel is read from the line stores, shifted into the window
// and checked; an interior pixel then takes nine MAC steps, the divider steps
// and a step to post the result, paced by the shared multiplier and the
// one-bit-per-cycle divider, plus any wait for the previous result beat to be
// taken. Configuration must be written only while the block is idle; unchecked.
module conv3x3_abs_saturate #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  c3as_pkg::in_beat_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output c3as_pkg::out_beat_t  m_data,
    input  wire                  cfg_we,
    input  wire [2:0]            cfg_idx,
    input  wire [23:0]           cfg_data
);
    import c3as_pkg::*;

    c3as_cmd_t cmd;
    c3as_sts_t sts;

    c3as_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    c3as_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (s_data),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .result   (m_data)
    );
endmodule
`default_nettype wire

// ----- design/c3as_datapath.sv -----
`default_nettype none
module c3as_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  c3as_pkg::in_beat_t    in_beat,
    input  c3as_pkg::c3as_cmd_t   cmd,
    output c3as_pkg::c3as_sts_t   sts,
    input  wire                   cfg_we,
    input  wire [2:0]             cfg_idx,
    input  wire [23:0]            cfg_data,
    output c3as_pkg::out_beat_t   result
);
    import c3as_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int QW = SumW + 1;

    // Configuration registers.
    logic [23:0] coef_reg [3];
    logic [7:0]  div_reg;
    logic [10:0] width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= 24'h0;
            coef_reg[1] <= 24'h010000;
            coef_reg[2] <= 24'h0;
            div_reg     <= 8'd1;
            width_reg   <= 11'd1024;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_COEF_TOP: coef_reg[0] <= cfg_data;
                REG_COEF_MID: coef_reg[1] <= cfg_data;
                REG_COEF_BOT: coef_reg[2] <= cfg_data;
                REG_DIVISOR:  div_reg     <= cfg_data[7:0];
                REG_WIDTH:    width_reg   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // Effective width, clamped to the legal range.
    logic [CW-1:0] eff_w;
    always_comb begin
        if (width_reg < 11'd3) begin
            eff_w = CW'(3);
        end else if ({21'd0, width_reg} > 32'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(width_reg);
        end
    end

    // Counters and beat capture.
    logic [CW-1:0] col_reg, col_use;
    logic [RW-1:0] row_reg, row_use;
    logic [7:0]    px_reg;
    logic [AW-1:0] addr_reg;
    logic [CW-1:0] ccur_reg;
    logic [RW-1:0] rcur_reg;
    logic          emit_reg;

    assign col_use = in_beat.frame_start ? '0 : col_reg;
    assign row_use = in_beat.frame_start ? '0 : row_reg;

    // Line stores: read at load, written at shift.
    logic [7:0] store_a [MAX_WIDTH];
    logic [7:0] store_b [MAX_WIDTH];
    logic [7:0] top_reg, mid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            top_reg <= store_b[col_use[AW-1:0]];
            mid_reg <= store_a[col_use[AW-1:0]];
        end
        if (cmd.shift) begin
            store_b[addr_reg] <= mid_reg;
            store_a[addr_reg] <= px_reg;
        end
    end

    logic [7:0] win_reg [9];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            emit_reg <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= 8'd0;
        end else begin
            if (cmd.load) begin
                px_reg   <= in_beat.pixel;
                addr_reg <= col_use[AW-1:0];
                ccur_reg <= col_use;
                rcur_reg <= row_use;
                if (col_use + CW'(1) >= eff_w) begin
                    col_reg <= '0;
                    if (row_use != RW'(MAX_HEIGHT - 1)) row_reg <= row_use + RW'(1);
                    else row_reg <= row_use;
                end else begin
                    col_reg <= col_use + CW'(1);
                    row_reg <= row_use;
                end
            end
            if (cmd.shift) begin
                for (int k = 0; k < 3; k++) begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2] <= top_reg;
                win_reg[5] <= mid_reg;
                win_reg[8] <= px_reg;
                emit_reg   <= (rcur_reg >= RW'(2)) && (addr_reg >= AW'(2));
            end
        end
    end

    assign sts.emit = emit_reg;

    // Multiply-accumulate, one tap per cycle.
    logic [1:0] trow, tcol;
    logic signed [7:0] coef_sel;
    logic signed [16:0] prod;
    logic signed [SumW-1:0] acc_reg;

    always_comb begin
        trow = 2'd0;
        tcol = 2'd0;
        unique case (cmd.tap)
            4'd0: begin trow = 2'd0; tcol = 2'd0; end
            4'd1: begin trow = 2'd0; tcol = 2'd1; end
            4'd2: begin trow = 2'd0; tcol = 2'd2; end
            4'd3: begin trow = 2'd1; tcol = 2'd0; end
            4'd4: begin trow = 2'd1; tcol = 2'd1; end
            4'd5: begin trow = 2'd1; tcol = 2'd2; end
            4'd6: begin trow = 2'd2; tcol = 2'd0; end
            4'd7: begin trow = 2'd2; tcol = 2'd1; end
            4'd8: begin trow = 2'd2; tcol = 2'd2; end
            default: ;
        endcase
        coef_sel = coef_reg[trow][tcol*8 +: 8];
        prod = coef_sel * $signed({1'b0, win_reg[cmd.tap]});
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_mac) acc_reg <= '0;
        else if (cmd.mac) acc_reg <= acc_reg + SumW'(prod);
    end

    // Restoring divider on the magnitude; truncation toward zero.
    logic [7:0]    d_eff;
    logic signed [QW-1:0] num;
    logic [QW-1:0] rem_reg, quo_reg;
    logic [QW:0]   trial;

    assign d_eff = (div_reg == 8'd0) ? 8'd1 : div_reg;
    assign num   = QW'(acc_reg) + QW'({1'b0, d_eff} + 9'd1) / 2;
    assign trial = {rem_reg, quo_reg[QW-1]} - (QW+1)'(d_eff);

    always_ff @(posedge aclk) begin
        if (cmd.start_div) begin
            quo_reg <= num[QW-1] ? QW'(-num) : QW'(num);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            if (!trial[QW]) begin
                rem_reg <= trial[QW-1:0];
                quo_reg <= {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[QW-2:0], quo_reg[QW-1]};
                quo_reg <= {quo_reg[QW-2:0], 1'b0};
            end
        end
    end

    // Clamp and register the result beat.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            result.out_pixel <= (quo_reg > QW'(255)) ? 8'd255 : quo_reg[7:0];
            result.out_row   <= 12'(rcur_reg - RW'(1));
            result.out_col   <= 10'(ccur_reg - CW'(1));
        end
    end
endmodule
`default_nettype wire

// ----- design/c3as_ctrl.sv -----
`default_nettype none
module c3as_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    output c3as_pkg::c3as_cmd_t cmd,
    input  c3as_pkg::c3as_sts_t sts
);
    import c3as_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SHIFT = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;
    localparam int QW = SumW + 1;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       mv_reg, mv_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    // Sequencer: load, shift, check; if emit: nine MAC taps, divide, post.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                cmd.shift  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.start_mac = 1'b1;
                cnt_next      = 5'd0;
                state_next    = sts.emit ? ST_MAC : ST_IDLE;
            end
            ST_MAC: begin
                cmd.mac = 1'b1;
                cmd.tap = cnt_reg[3:0];
                if (cnt_reg == 5'd8) begin
                    state_next = ST_DIV;
                    cnt_next   = 5'd0;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_DIV: begin
                if (cnt_reg == 5'd0) cmd.start_div = 1'b1;
                else cmd.div_step = 1'b1;
                if (cnt_reg == 5'(QW)) state_next = ST_DONE;
                cnt_next = cnt_reg + 5'd1;
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end
endmodule
`default_nettype wire
